// ===== rtl/core/cpio_pkg.sv =====
// Shared types and constants for the cpio archive stream parser.
package cpio_pkg;

  typedef enum logic [2:0] {
    KIND_NAME    = 3'd0,
    KIND_DESC    = 3'd1,
    KIND_CONTENT = 3'd2,
    KIND_END     = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    FMT_BIN_LE    = 3'd0,
    FMT_BIN_BE    = 3'd1,
    FMT_ODC       = 3'd2,
    FMT_NEWC      = 3'd3,
    FMT_NEWC_CRC  = 3'd4
  } format_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MAGIC     = 2'd1,
    ERR_LINK_LONG = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ET_DIR     = 2'd0,
    ET_SYMLINK = 2'd1,
    ET_REGULAR = 2'd2,
    ET_OTHER   = 2'd3
  } etype_t;

  typedef enum logic [4:0] {
    PH_MAGIC   = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_NAME    = 5'b00100,
    PH_CONTENT = 5'b01000,
    PH_PAD     = 5'b10000
  } phase_t;

  typedef enum logic [0:0] {
    REQ_BYTE    = 1'b0,
    REQ_RESTART = 1'b1
  } req_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    etype_t     entry_type;
    logic [31:0] entry_mode;
    logic [31:0] entry_size;
    format_t    archive_format;
    err_t       error_code;
    logic       last_content;
  } result_t;

  typedef struct packed {
    logic [7:0] ch;
  } trailer_ch_t;

  localparam logic [7:0] TRAILER_NAME [10] = '{
    8'h54, 8'h52, 8'h41, 8'h49, 8'h4C, 8'h45, 8'h52, 8'h21, 8'h21, 8'h21
  };

  function automatic etype_t entry_type_of(input logic [31:0] mode);
    logic [3:0] t;
    t = mode[15:12];
    case (t)
      4'o04:   entry_type_of = ET_DIR;
      4'o12:   entry_type_of = ET_SYMLINK;
      4'o10:   entry_type_of = ET_REGULAR;
      default: entry_type_of = ET_OTHER;
    endcase
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) v = 4'(b - 8'h30);
    else if (b >= 8'h41 && b <= 8'h46) v = 4'(b - 8'h37);
    else if (b >= 8'h61 && b <= 8'h66) v = 4'(b - 8'h57);
    hex_value = v;
  endfunction

endpackage

// ===== rtl/core/cpio_if.sv =====
// Valid/ready stream interfaces for the parser's input and result channels.
interface cpio_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  modport source (output valid, req_type, data_byte, input ready);
  modport sink   (input valid, req_type, data_byte, output ready);
endinterface

interface cpio_out_if;
  logic              valid;
  logic              ready;
  cpio_pkg::result_t res;
  modport source (output valid, res, input ready);
  modport sink   (input valid, res, output ready);
endinterface

// ===== rtl/core/cpio_out_queue.sv =====
// Result queue: takes up to two results per cycle, delivers one per transfer.
module cpio_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  cpio_pkg::result_t push0,
  input  cpio_pkg::result_t push1,
  output logic [2:0]        free_cnt,
  cpio_out_if.source        out_ch
);
  // four entries, circular
  cpio_pkg::result_t mem_r [4];
  logic [1:0] rd_r, rd_nxt, wr_r, wr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic pop;

  assign pop = out_ch.valid && out_ch.ready;
  assign out_ch.valid = (cnt_r != 3'd0);
  assign out_ch.res = mem_r[rd_r];
  assign free_cnt = 3'd4 - cnt_r;

  always_comb begin
    rd_nxt  = rd_r + {1'b0, pop};
    wr_nxt  = wr_r + push_cnt;
    cnt_nxt = cnt_r + {1'b0, push_cnt} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wr_r + 2'd1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      rd_r <= rd_nxt; wr_r <= wr_nxt; cnt_r <= cnt_nxt;
    end
  end
endmodule

// ===== rtl/core/cpio_archive_stream_parser.sv =====
// Top level of the cpio archive stream parser.
// A result is registered in the result queue when the byte that causes it is taken.
// Throughput: one archive byte per cycle while the four-entry result queue
//   has room for two results; each byte produces at most two results.
// Reset: synchronous, active low; clears all parse state to magic detection.
// A restart request clears the parse state as reset does, but leaves the result queue, and gives no result.
module cpio_archive_stream_parser #(
  parameter int LINK_LIMIT = 256
) (
  input logic        clk,
  input logic        rst_n,
  cpio_in_if.sink    in_ch,
  cpio_out_if.source out_ch
);
  localparam int LW = $clog2(LINK_LIMIT + 1);

  cpio_pkg::phase_t phase_r, phase_nxt;
  cpio_pkg::format_t format_r, format_nxt;
  logic [31:0] count_r, count_nxt;
  logic [47:0] magic_r, magic_nxt;
  logic [31:0] mode_r, mode_nxt, size_r, size_nxt, nsize_r, nsize_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        strip_r, strip_nxt;
  logic [3:0]  tidx_r, tidx_nxt;
  logic        tmiss_r, tmiss_nxt, stop_r, stop_nxt, ndone_r, ndone_nxt;

  logic [1:0]  push_cnt;
  logic [2:0]  free_cnt;
  cpio_pkg::result_t push0, push1;
  logic        take;
  logic [7:0]  b;

  assign in_ch.ready = (free_cnt >= 3'd2);
  assign take = in_ch.valid && in_ch.ready;
  assign b = in_ch.data_byte;

  // results carry the state as it stands after the step's updates
  function automatic cpio_pkg::result_t mk(input cpio_pkg::kind_t k, input logic [7:0] d,
      input cpio_pkg::err_t e, input logic l, input logic [31:0] m, input logic [31:0] s,
      input cpio_pkg::format_t f);
    cpio_pkg::result_t r;
    r.kind = k; r.out_byte = d; r.entry_type = cpio_pkg::entry_type_of(m);
    r.entry_mode = m; r.entry_size = s; r.archive_format = f;
    r.error_code = e; r.last_content = l;
    mk = r;
  endfunction

  always_comb begin
    logic [31:0] ns, hl;
    logic [1:0]  a;
    logic        fin, last, lk_long;
    logic [7:0]  m0, m1;
    logic [2:0]  bsh;
    phase_nxt = phase_r; format_nxt = format_r; count_nxt = count_r;
    magic_nxt = magic_r; mode_nxt = mode_r; size_nxt = size_r; nsize_nxt = nsize_r;
    pad_nxt = pad_r; strip_nxt = strip_r; tidx_nxt = tidx_r; tmiss_nxt = tmiss_r;
    stop_nxt = stop_r; ndone_nxt = ndone_r;
    push_cnt = 2'd0; push0 = '0; push1 = '0;
    ns = '0; hl = '0; a = '0; fin = 1'b0; last = 1'b0; m0 = '0; m1 = '0; bsh = '0;
    lk_long = 1'b0;
    if (take && in_ch.req_type == cpio_pkg::REQ_RESTART) begin
      phase_nxt = cpio_pkg::PH_MAGIC; format_nxt = cpio_pkg::FMT_BIN_LE; count_nxt = '0;
      magic_nxt = '0; mode_nxt = '0; size_nxt = '0; nsize_nxt = '0; pad_nxt = '0;
      strip_nxt = 1'b1; tidx_nxt = '0; tmiss_nxt = 1'b0; stop_nxt = 1'b0; ndone_nxt = 1'b0;
    end else if (take && !stop_r) begin
      case (phase_r)
        cpio_pkg::PH_MAGIC: begin
          // the magic is the start of the first header: the offset runs on
          magic_nxt = {magic_r[39:0], b};
          count_nxt = count_r + 32'd1;
          if (count_r == 32'd5) begin
            m0 = magic_r[39:32]; m1 = magic_r[31:24];
            if (m0 == 8'hC7 && m1 == 8'h71) begin
              format_nxt = cpio_pkg::FMT_BIN_LE; phase_nxt = cpio_pkg::PH_HEADER;
            end else if (m0 == 8'h71 && m1 == 8'hC7) begin
              format_nxt = cpio_pkg::FMT_BIN_BE; phase_nxt = cpio_pkg::PH_HEADER;
            end else if (magic_r[39:0] == 40'h3037303730 && b == 8'h37) begin
              format_nxt = cpio_pkg::FMT_ODC; phase_nxt = cpio_pkg::PH_HEADER;
            end else if (magic_r[39:0] == 40'h3037303730 && b == 8'h31) begin
              format_nxt = cpio_pkg::FMT_NEWC; phase_nxt = cpio_pkg::PH_HEADER;
            end else if (magic_r[39:0] == 40'h3037303730 && b == 8'h32) begin
              format_nxt = cpio_pkg::FMT_NEWC_CRC; phase_nxt = cpio_pkg::PH_HEADER;
            end else begin
              push_cnt = 2'd1; stop_nxt = 1'b1;
              push0 = mk(cpio_pkg::KIND_ERROR, 8'd0, cpio_pkg::ERR_MAGIC, 1'b0,
                         mode_r, size_r, format_r);
            end
          end
        end
        cpio_pkg::PH_HEADER: begin
          // binary fields: byte lane from offset parity and endianness
          bsh = (format_r == cpio_pkg::FMT_BIN_LE) ? {count_r[0], 2'b0} : {~count_r[0], 2'b0};
          if (format_r == cpio_pkg::FMT_BIN_LE || format_r == cpio_pkg::FMT_BIN_BE) begin
            hl = 32'd26;
            if (count_r == 32'd6 || count_r == 32'd7)
              mode_nxt = mode_r | ({24'd0, b} << {bsh, 1'b0});
            else if (count_r == 32'd20 || count_r == 32'd21)
              nsize_nxt = nsize_r | ({24'd0, b} << {bsh, 1'b0});
            else if (count_r == 32'd22 || count_r == 32'd23)
              size_nxt = size_r | ({8'd0, b, 16'd0} << {bsh, 1'b0});
            else if (count_r == 32'd24 || count_r == 32'd25)
              size_nxt = size_r | ({24'd0, b} << {bsh, 1'b0});
          end else if (format_r == cpio_pkg::FMT_ODC) begin
            hl = 32'd76;
            if (count_r >= 32'd18 && count_r < 32'd24) mode_nxt = {mode_r[28:0], b[2:0]};
            else if (count_r >= 32'd59 && count_r < 32'd65)
              nsize_nxt = {nsize_r[28:0], b[2:0]};
            else if (count_r >= 32'd65 && count_r < 32'd76)
              size_nxt = {size_r[28:0], b[2:0]};
          end else begin
            hl = 32'd110;
            if (count_r >= 32'd14 && count_r < 32'd22)
              mode_nxt = {mode_r[27:0], cpio_pkg::hex_value(b)};
            else if (count_r >= 32'd54 && count_r < 32'd62)
              size_nxt = {size_r[27:0], cpio_pkg::hex_value(b)};
            else if (count_r >= 32'd94 && count_r < 32'd102)
              nsize_nxt = {nsize_r[27:0], cpio_pkg::hex_value(b)};
          end
          count_nxt = count_r + 32'd1;
          if (count_nxt == hl) begin
            ns = nsize_nxt;
            if (format_r == cpio_pkg::FMT_BIN_LE || format_r == cpio_pkg::FMT_BIN_BE)
              ns = (ns + 32'd1) & ~32'd1;
            else if (format_r != cpio_pkg::FMT_ODC)
              ns = ((ns + 32'd5) & ~32'd3) - 32'd2;
            nsize_nxt = ns; phase_nxt = cpio_pkg::PH_NAME; count_nxt = '0;
            fin = (ns == 32'd0);
          end
        end
        cpio_pkg::PH_NAME: begin
          if (!ndone_r) begin
            if (b == 8'd0) ndone_nxt = 1'b1;
            else if (!(strip_r && b == 8'h2F)) begin
              strip_nxt = 1'b0; push_cnt = 2'd1;
              push0 = mk(cpio_pkg::KIND_NAME, b, cpio_pkg::ERR_NONE, 1'b0,
                         mode_r, size_r, format_r);
              if (tidx_r < 4'd10 && b == cpio_pkg::TRAILER_NAME[tidx_r])
                tidx_nxt = tidx_r + 4'd1;
              else tmiss_nxt = 1'b1;
            end
          end
          count_nxt = count_r + 32'd1;
          fin = (count_nxt == nsize_r);
        end
        cpio_pkg::PH_CONTENT: begin
          last = (count_r + 32'd1 == size_r);
          if (cpio_pkg::entry_type_of(mode_r) == cpio_pkg::ET_SYMLINK ||
              cpio_pkg::entry_type_of(mode_r) == cpio_pkg::ET_REGULAR) begin
            push_cnt = 2'd1;
            push0 = mk(cpio_pkg::KIND_CONTENT, b, cpio_pkg::ERR_NONE, last,
                       mode_r, size_r, format_r);
          end
          count_nxt = count_r + 32'd1;
        end
        cpio_pkg::PH_PAD: begin
          pad_nxt = pad_r - 2'd1;
          if (pad_nxt == 2'd0) phase_nxt = cpio_pkg::PH_MAGIC;
        end
        default: stop_nxt = 1'b1;
      endcase

      if (fin) begin
        lk_long = (size_nxt >= 32'(LINK_LIMIT)) &&
                  (size_nxt[LW-1:0] == size_nxt[LW-1:0]);
        if (!tmiss_nxt && tidx_nxt == 4'd10) begin
          push1 = mk(cpio_pkg::KIND_END, 8'd0, cpio_pkg::ERR_NONE, 1'b0,
                     mode_nxt, size_nxt, format_r);
          stop_nxt = 1'b1;
        end else if (cpio_pkg::entry_type_of(mode_nxt) == cpio_pkg::ET_SYMLINK && lk_long) begin
          push1 = mk(cpio_pkg::KIND_ERROR, 8'd0, cpio_pkg::ERR_LINK_LONG, 1'b0,
                     mode_nxt, size_nxt, format_r);
          stop_nxt = 1'b1;
        end else begin
          push1 = mk(cpio_pkg::KIND_DESC, 8'd0, cpio_pkg::ERR_NONE, 1'b0,
                     mode_nxt, size_nxt, format_r);
          if (size_nxt != 32'd0) begin
            phase_nxt = cpio_pkg::PH_CONTENT; count_nxt = '0;
          end else last = 1'b1;
        end
        if (push_cnt == 2'd0) push0 = push1;
        push_cnt = push_cnt + 2'd1;
      end

      // content end or empty entry: pad to alignment, else next header
      if (last && !stop_nxt) begin
        if (format_r == cpio_pkg::FMT_BIN_LE || format_r == cpio_pkg::FMT_BIN_BE)
          a = {1'b0, size_nxt[0]};
        else if (format_r == cpio_pkg::FMT_ODC) a = 2'd0;
        else a = 2'd0 - size_nxt[1:0];
        if (a == 2'd0) phase_nxt = cpio_pkg::PH_MAGIC;
        else begin
          pad_nxt = a; phase_nxt = cpio_pkg::PH_PAD;
        end
      end

      // entering a new header: PH_MAGIC used above as a marker for this
      if (phase_r != cpio_pkg::PH_MAGIC && phase_nxt == cpio_pkg::PH_MAGIC) begin
        phase_nxt = cpio_pkg::PH_HEADER; count_nxt = '0; mode_nxt = '0; size_nxt = '0;
        nsize_nxt = '0; pad_nxt = '0; strip_nxt = 1'b1; tidx_nxt = '0;
        tmiss_nxt = 1'b0; ndone_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cpio_pkg::PH_MAGIC; format_r <= cpio_pkg::FMT_BIN_LE; count_r <= '0;
      magic_r <= '0; mode_r <= '0; size_r <= '0; nsize_r <= '0; pad_r <= '0;
      strip_r <= 1'b1; tidx_r <= '0; tmiss_r <= 1'b0; stop_r <= 1'b0; ndone_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; format_r <= format_nxt; count_r <= count_nxt;
      magic_r <= magic_nxt; mode_r <= mode_nxt; size_r <= size_nxt; nsize_r <= nsize_nxt;
      pad_r <= pad_nxt; strip_r <= strip_nxt; tidx_r <= tidx_nxt; tmiss_r <= tmiss_nxt;
      stop_r <= stop_nxt; ndone_r <= ndone_nxt;
    end
  end

  cpio_out_queue u_queue (
    .clk, .rst_n, .push_cnt, .push0, .push1, .free_cnt, .out_ch
  );
endmodule

// ===== rtl/core/cpio_checker.sv =====
// Port-level checks for the parser, bound to the top level.
module cpio_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [1:0] error_code,
  input logic       last_content
);
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid) else $error("input transfer withdrawn");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != cpio_pkg::KIND_ERROR |-> error_code == cpio_pkg::ERR_NONE)
    else $error("error code outside error result");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_content |-> kind == cpio_pkg::KIND_CONTENT)
    else $error("last flag outside content");
endmodule

bind cpio_archive_stream_parser cpio_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .kind(out_ch.res.kind),
  .error_code(out_ch.res.error_code), .last_content(out_ch.res.last_content)
);
